### hw/rtl/tprs_pkg.sv
`timescale 1ns / 1ps

package tprs_pkg;

   // field and datapath widths
   localparam int COORD_W = 12;                  // raw and screen coordinates
   localparam int ROT_W   = 16;                  // rotated coordinate, wraps mod 2^16
   localparam int Q_W     = 12;                  // quotient bits, one per divider cell
   localparam int D_W     = 13;                  // divisor (widened span) width
   localparam int P_W     = D_W + Q_W;           // product / partial remainder width
   localparam int CSR_IDX_W = 3;

   // margin added on both sides of each raw calibration range
   localparam int MAP_MARGIN = 10;

   // accept edge to strobe edge: three front stages, one per cell, one output stage
   localparam int PIPE_LAT = 3 + Q_W + 1;

   // rotation codes
   localparam logic [1:0] ROT_NONE     = 2'd0;
   localparam logic [1:0] ROT_LEFT     = 2'd1;
   localparam logic [1:0] ROT_INVERTED = 2'd2;
   localparam logic [1:0] ROT_RIGHT    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_X_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_X_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_Y_MIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_Y_MAX     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_MODE   = 3'd7;

   // register reset values
   localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
   localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
   localparam logic [COORD_W-1:0] RST_RAW_X_MAX     = 12'd320;
   localparam logic [COORD_W-1:0] RST_RAW_Y_MAX     = 12'd480;

   typedef struct packed {
      logic [1:0]         rotation;
      logic [COORD_W-1:0] screen_width;
      logic [COORD_W-1:0] screen_height;
      logic [COORD_W-1:0] raw_x_min;
      logic [COORD_W-1:0] raw_x_max;
      logic [COORD_W-1:0] raw_y_min;
      logic [COORD_W-1:0] raw_y_max;
      logic [1:0]         invert_mode;
   } cfg_type;

   // clamped axis ahead of the multiply
   typedef struct packed {
      logic [D_W-1:0] delta;
      logic [D_W-1:0] span;
      logic           sat;
   } prep_type;

   // one axis as it walks the divider row
   typedef struct packed {
      logic           sat;
      logic [P_W-1:0] rem;
      logic [D_W-1:0] div;
      logic [Q_W-1:0] quo;
   } axis_type;

   typedef struct packed {
      logic     vld;
      logic     touch;
      axis_type x;
      axis_type y;
   } lane_type;

endpackage

### hw/rtl/tprs_front.sv
`timescale 1ns / 1ps

module tprs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  tprs_pkg::cfg_type        cfg,
   input  logic                     read_failed,
   input  logic [7:0]               status_byte,
   input  logic [7:0]               x_high_byte,
   input  logic [7:0]               x_low_byte,
   input  logic [7:0]               y_high_byte,
   input  logic [7:0]               y_low_byte,
   output tprs_pkg::lane_type       lane_out
);

   localparam int CW = tprs_pkg::COORD_W;
   localparam int RW = tprs_pkg::ROT_W;
   localparam int DW = tprs_pkg::D_W;
   localparam int PW = tprs_pkg::P_W;

   // clamp one axis to its widened range and report distance and span
   function automatic tprs_pkg::prep_type clamp_axis(
      input logic [RW-1:0] v,
      input logic [CW-1:0] lo,
      input logic [CW-1:0] hi,
      input logic          zero_scr
   );
      tprs_pkg::prep_type  p;
      logic signed [RW:0]  v_s;
      logic signed [RW:0]  lo_s;
      logic signed [RW:0]  hi_s;
      logic signed [RW:0]  diff;
      logic signed [RW:0]  span_s;
      logic                empty;
      v_s    = $signed({1'b0, v});
      lo_s   = $signed({{(RW+1-CW){1'b0}}, lo}) - $signed((RW+1)'(tprs_pkg::MAP_MARGIN));
      hi_s   = $signed({{(RW+1-CW){1'b0}}, hi}) + $signed((RW+1)'(tprs_pkg::MAP_MARGIN));
      diff   = v_s - lo_s;
      span_s = hi_s - lo_s;
      empty  = (hi <= lo);
      p.span = span_s[DW-1:0];
      if (v_s < lo_s) begin
         p.delta = '0;
      end else if (v_s > hi_s) begin
         p.delta = p.span;
      end else begin
         p.delta = diff[DW-1:0];
      end
      // a zero screen size scales by minus one: only the top end survives, as all ones
      p.sat = zero_scr & ~empty & (p.delta == p.span);
      // an empty range maps to zero
      if (empty) begin
         p.delta = '0;
         p.span  = DW'(1);
      end
      return p;
   endfunction

   // stage 1: decode the report and rotate
   logic          vld1_ff, touch1_ff;
   logic [RW-1:0] tx1_ff, ty1_ff;
   logic [CW-1:0] xlo1_ff, xhi1_ff, ylo1_ff, yhi1_ff;

   logic [3:0]    count;
   logic          touch_in;
   logic [RW-1:0] rx, ry, tx_in, ty_in, rxd, ryd;
   logic          swap;

   always_comb begin
      count    = status_byte[3:0];
      touch_in = ~read_failed & (status_byte != 8'd0) & (count <= 4'd2);
      rx       = {{(RW-CW){1'b0}}, x_high_byte[3:0], x_low_byte};
      ry       = {{(RW-CW){1'b0}}, y_high_byte[3:0], y_low_byte};
      rxd      = {{(RW-CW){1'b0}}, cfg.raw_x_max} - rx;
      ryd      = {{(RW-CW){1'b0}}, cfg.raw_y_max} - ry;
      swap     = (cfg.rotation == tprs_pkg::ROT_LEFT) || (cfg.rotation == tprs_pkg::ROT_RIGHT);
      case (cfg.rotation)
         tprs_pkg::ROT_LEFT: begin
            tx_in = ryd;
            ty_in = rx;
         end
         tprs_pkg::ROT_INVERTED: begin
            tx_in = rxd;
            ty_in = ryd;
         end
         tprs_pkg::ROT_RIGHT: begin
            tx_in = ry;
            ty_in = rxd;
         end
         default: begin
            tx_in = rx;
            ty_in = ry;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= fire;
      end
      touch1_ff <= touch_in;
      tx1_ff    <= tx_in;
      ty1_ff    <= ty_in;
      xlo1_ff   <= swap ? cfg.raw_y_min : cfg.raw_x_min;
      xhi1_ff   <= swap ? cfg.raw_y_max : cfg.raw_x_max;
      ylo1_ff   <= swap ? cfg.raw_x_min : cfg.raw_y_min;
      yhi1_ff   <= swap ? cfg.raw_x_max : cfg.raw_y_max;
   end

   // stage 2: clamp and pick the scale factors
   logic               vld2_ff, touch2_ff;
   tprs_pkg::prep_type px2_ff, py2_ff;
   logic [CW-1:0]      topx2_ff, topy2_ff;

   logic zero_w, zero_h;
   assign zero_w = (cfg.screen_width == '0);
   assign zero_h = (cfg.screen_height == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      touch2_ff <= touch1_ff;
      px2_ff    <= clamp_axis(tx1_ff, xlo1_ff, xhi1_ff, zero_w);
      py2_ff    <= clamp_axis(ty1_ff, ylo1_ff, yhi1_ff, zero_h);
      topx2_ff  <= zero_w ? '0 : cfg.screen_width - CW'(1);
      topy2_ff  <= zero_h ? '0 : cfg.screen_height - CW'(1);
   end

   // stage 3: multiply distance by screen extent
   tprs_pkg::lane_type lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.vld <= 1'b0;
      end else begin
         lane_ff.vld <= vld2_ff;
      end
      lane_ff.touch <= touch2_ff;
      lane_ff.x.sat <= px2_ff.sat;
      lane_ff.x.rem <= PW'(px2_ff.delta) * PW'(topx2_ff);
      lane_ff.x.div <= px2_ff.span;
      lane_ff.x.quo <= '0;
      lane_ff.y.sat <= py2_ff.sat;
      lane_ff.y.rem <= PW'(py2_ff.delta) * PW'(topy2_ff);
      lane_ff.y.div <= py2_ff.span;
      lane_ff.y.quo <= '0;
   end

   assign lane_out = lane_ff;

endmodule

### hw/rtl/tprs_div_cell.sv
`timescale 1ns / 1ps

module tprs_div_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  tprs_pkg::lane_type lane_in,
   output tprs_pkg::lane_type lane_out
);

   localparam int PW = tprs_pkg::P_W;

   // resolve one quotient bit: subtract the divisor shifted to this bit if it fits
   function automatic tprs_pkg::axis_type div_step(input tprs_pkg::axis_type a);
      tprs_pkg::axis_type r;
      logic [PW-1:0]      sh;
      r  = a;
      sh = PW'(a.div) << BIT;
      if (a.rem >= sh) begin
         r.rem      = a.rem - sh;
         r.quo[BIT] = 1'b1;
      end
      return r;
   endfunction

   tprs_pkg::lane_type lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.vld <= 1'b0;
      end else begin
         lane_ff.vld <= lane_in.vld;
      end
      lane_ff.touch <= lane_in.touch;
      lane_ff.x     <= div_step(lane_in.x);
      lane_ff.y     <= div_step(lane_in.y);
   end

   assign lane_out = lane_ff;

endmodule

### hw/rtl/touch_point_rotate_and_scale.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Transfer
// -------   -------------------------------------   -------------------------------
// request   start, busy, req_*                      edge with start high, busy low
// result    rsp_strobe, rsp_touched, rsp_point_*    edge ending the strobe cycle
// config    csr_we, csr_index, csr_wdata            edge with csr_we high
//
// One report per cycle; every report gives one result, registered in turn through
// three front stages (decode and rotate, clamp, multiply), twelve divider cells
// (one quotient bit each) and the output register.
// busy is high only during reset; reset clears the pipeline and loads register defaults.
// The receiver takes every result as it comes; nothing stalls.

module touch_point_rotate_and_scale (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_read_failed,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_x_high_byte,
   input  logic [7:0]  req_x_low_byte,
   input  logic [7:0]  req_y_high_byte,
   input  logic [7:0]  req_y_low_byte,
   output logic        rsp_strobe,
   output logic        rsp_touched,
   output logic [11:0] rsp_point_x,
   output logic [11:0] rsp_point_y,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int CW = tprs_pkg::COORD_W;
   localparam int QW = tprs_pkg::Q_W;

   logic fire;
   assign busy = reset;
   assign fire = start & ~busy;

   // configuration registers
   tprs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation      <= tprs_pkg::ROT_NONE;
         cfg_ff.screen_width  <= tprs_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= tprs_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.raw_x_min     <= '0;
         cfg_ff.raw_x_max     <= tprs_pkg::RST_RAW_X_MAX;
         cfg_ff.raw_y_min     <= '0;
         cfg_ff.raw_y_max     <= tprs_pkg::RST_RAW_Y_MAX;
         cfg_ff.invert_mode   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tprs_pkg::REG_ROTATION:      cfg_ff.rotation      <= csr_wdata[1:0];
            tprs_pkg::REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata;
            tprs_pkg::REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata;
            tprs_pkg::REG_RAW_X_MIN:     cfg_ff.raw_x_min     <= csr_wdata;
            tprs_pkg::REG_RAW_X_MAX:     cfg_ff.raw_x_max     <= csr_wdata;
            tprs_pkg::REG_RAW_Y_MIN:     cfg_ff.raw_y_min     <= csr_wdata;
            tprs_pkg::REG_RAW_Y_MAX:     cfg_ff.raw_y_max     <= csr_wdata;
            tprs_pkg::REG_INVERT_MODE:   cfg_ff.invert_mode   <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // front stages
   tprs_pkg::lane_type chain [0:QW];

   tprs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cfg         (cfg_ff),
      .read_failed (req_read_failed),
      .status_byte (req_status_byte),
      .x_high_byte (req_x_high_byte),
      .x_low_byte  (req_x_low_byte),
      .y_high_byte (req_y_high_byte),
      .y_low_byte  (req_y_low_byte),
      .lane_out    (chain[0])
   );

   // divider row, most significant quotient bit first
   for (genvar i = 0; i < QW; i++) begin : g_cell
      tprs_div_cell #(
         .BIT (QW - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (chain[i]),
         .lane_out (chain[i+1])
      );
   end

   // saturate, mirror, zero untouched points and register the result
   tprs_pkg::lane_type last;
   logic [CW-1:0]      base_x, base_y, px_in, py_in;
   logic               strobe_ff, touched_ff;
   logic [CW-1:0]      px_ff, py_ff;

   always_comb begin
      last   = chain[QW];
      base_x = last.x.sat ? '1 : last.x.quo;
      base_y = last.y.sat ? '1 : last.y.quo;
      px_in  = base_x;
      py_in  = base_y;
      if (cfg_ff.invert_mode[0] && (cfg_ff.screen_width != '0)) begin
         px_in = cfg_ff.screen_width - CW'(1) - base_x;
      end
      if (cfg_ff.invert_mode[1] && (cfg_ff.screen_height != '0)) begin
         py_in = cfg_ff.screen_height - CW'(1) - base_y;
      end
      if (!last.touch) begin
         px_in = '0;
         py_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= last.vld;
      end
      touched_ff <= last.touch;
      px_ff      <= px_in;
      py_ff      <= py_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_touched = touched_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;

   // every result traces back to an earlier request transfer
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(fire, tprs_pkg::PIPE_LAT))
      else $error("result without matching request");

   // a report with no touch carries a zero point
   a_no_touch_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_touched |-> rsp_point_x == '0 && rsp_point_y == '0)
      else $error("untouched result has nonzero point");

   // the divider row leaves a remainder below the divisor
   a_rem_x : assert property (@(posedge clock) disable iff (reset)
      last.vld |-> last.x.rem < tprs_pkg::P_W'(last.x.div))
      else $error("x remainder not reduced");

   a_rem_y : assert property (@(posedge clock) disable iff (reset)
      last.vld |-> last.y.rem < tprs_pkg::P_W'(last.y.div))
      else $error("y remainder not reduced");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic       read_failed;
      logic [7:0] status_byte;
      logic [7:0] x_high_byte;
      logic [7:0] x_low_byte;
      logic [7:0] y_high_byte;
      logic [7:0] y_low_byte;
   } report_type;

   typedef struct packed {
      logic                         touched;
      logic [tprs_pkg::COORD_W-1:0] x;
      logic [tprs_pkg::COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic [2:0] cfg_sel;
      report_type rpt;
      logic       typed;
      point_type  want;
   } directed_row_type;

   // invert_mode is a per-axis mirror mask
   localparam logic [1:0] MIRROR_NONE = 2'd0;
   localparam logic [1:0] MIRROR_X    = 2'd1;
   localparam logic [1:0] MIRROR_Y    = 2'd2;
   localparam logic [1:0] MIRROR_XY   = 2'd3;

   localparam int LIMIT       = 300000;
   localparam int N_PHASES    = 13;
   localparam int PHASE_ITEMS = 150;
   localparam int N_DIRECTED  = 22;

   // rotation, width, height, x min, x max, y min, y max, mirror
   // entry 0 holds the reset settings
   localparam tprs_pkg::cfg_type DIRECTED_CFGS [6] = '{
      '{tprs_pkg::ROT_NONE, 12'd320, 12'd480, 12'd0, 12'd320, 12'd0, 12'd480, MIRROR_NONE},
      '{tprs_pkg::ROT_LEFT, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, MIRROR_XY},
      '{tprs_pkg::ROT_INVERTED, 12'd1, 12'd2, 12'd100, 12'd200, 12'd50, 12'd60, MIRROR_X},
      '{tprs_pkg::ROT_RIGHT, 12'd0, 12'd0, 12'd500, 12'd500, 12'd300, 12'd200, MIRROR_XY},
      '{tprs_pkg::ROT_NONE, 12'd0, 12'd0, 12'd0, 12'd100, 12'd0, 12'd100, MIRROR_XY},
      '{tprs_pkg::ROT_RIGHT, 12'd640, 12'd4095, 12'd0, 12'd4095, 12'd20, 12'd3000, MIRROR_Y}
   };

   // settings, report {fail, status, xh, xl, yh, yl}, typed, point {touched, x, y}
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // no touch: bus failure, empty status, counts beyond two
      '{3'd0, '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 12'd0, 12'd0}},
      '{3'd0, '{1'b0, 8'h00, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b1, '{1'b0, 12'd0, 12'd0}},
      '{3'd0, '{1'b0, 8'h03, 8'h01, 8'h23, 8'h01, 8'h23}, 1'b1, '{1'b0, 12'd0, 12'd0}},
      '{3'd0, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b0, 12'd0, 12'd0}},
      // reset settings: raw zero and raw full scale
      '{3'd0, '{1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 12'd9, 12'd9}},
      '{3'd0, '{1'b0, 8'h02, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b1, '{1'b1, 12'd319, 12'd479}},
      // zero count with status set counts as one point; high nibbles ignored
      '{3'd0, '{1'b0, 8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 12'd319, 12'd479}},
      '{3'd0, '{1'b0, 8'hF1, 8'hF0, 8'hA0, 8'hF1, 8'h40}, 1'b0, '0},
      '{3'd0, '{1'b0, 8'hE2, 8'h00, 8'h55, 8'h01, 8'hAA}, 1'b0, '0},
      // left rotation, full panel, both axes mirrored
      '{3'd1, '{1'b0, 8'h01, 8'h0F, 8'hFF, 8'h00, 8'h00}, 1'b0, '0},
      '{3'd1, '{1'b0, 8'h02, 8'h00, 8'h00, 8'h0F, 8'hFF}, 1'b0, '0},
      '{3'd1, '{1'b0, 8'h81, 8'h08, 8'h00, 8'h08, 8'h00}, 1'b0, '0},
      // inverted rotation: raw above max wraps, tiny screen
      '{3'd2, '{1'b0, 8'h01, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b0, '0},
      '{3'd2, '{1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{3'd2, '{1'b0, 8'h02, 8'h00, 8'h96, 8'h00, 8'h37}, 1'b0, '0},
      // right rotation with empty ranges on both axes
      '{3'd3, '{1'b0, 8'h01, 8'h01, 8'hF4, 8'h00, 8'hC8}, 1'b1, '{1'b1, 12'd0, 12'd0}},
      '{3'd3, '{1'b0, 8'h02, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b1, '{1'b1, 12'd0, 12'd0}},
      '{3'd3, '{1'b1, 8'h02, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b1, '{1'b0, 12'd0, 12'd0}},
      // zero screen size: negative scale, no mirroring; then a wide panel rotated right, y mirrored
      '{3'd4, '{1'b0, 8'h01, 8'h0F, 8'hFF, 8'h00, 8'h00}, 1'b1, '{1'b1, 12'hFFF, 12'd0}},
      '{3'd4, '{1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h6E}, 1'b0, '0},
      '{3'd5, '{1'b0, 8'h01, 8'h0F, 8'hFF, 8'h0F, 8'hFF}, 1'b0, '0},
      '{3'd5, '{1'b0, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_read_failed = 1'b0;
   logic [7:0]  req_status_byte = 8'd0;
   logic [7:0]  req_x_high_byte = 8'd0;
   logic [7:0]  req_x_low_byte = 8'd0;
   logic [7:0]  req_y_high_byte = 8'd0;
   logic [7:0]  req_y_low_byte = 8'd0;
   logic        rsp_strobe;
   logic        rsp_touched;
   logic [11:0] rsp_point_x;
   logic [11:0] rsp_point_y;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [11:0] csr_wdata = 12'd0;

   tprs_pkg::cfg_type cfg_now = DIRECTED_CFGS[0];
   point_type pending_points[$];
   logic      typed_valid = 1'b0;
   point_type typed_point = '0;
   point_type got;
   point_type exp_pt;
   int        fail_count = 0;
   int        sent_count = 0;
   int        checked_count = 0;
   int        touched_count = 0;
   int        phase_count = 0;
   int        cycle_count = 0;

   touch_point_rotate_and_scale DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_read_failed (req_read_failed),
      .req_status_byte (req_status_byte),
      .req_x_high_byte (req_x_high_byte),
      .req_x_low_byte  (req_x_low_byte),
      .req_y_high_byte (req_y_high_byte),
      .req_y_low_byte  (req_y_low_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_touched     (rsp_touched),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // clamp to the widened range, then scale with truncating division; an empty range gives zero
   function automatic int fit_axis(int v, int lo, int hi, int top);
      if (hi <= lo) return 0;
      lo = lo - tprs_pkg::MAP_MARGIN;
      hi = hi + tprs_pkg::MAP_MARGIN;
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      return ((v - lo) * top) / (hi - lo);
   endfunction

   function automatic point_type map_touch(tprs_pkg::cfg_type c, report_type r);
      point_type   p;
      logic [11:0] rx, ry;
      logic [15:0] tx, ty;
      int          xlo, xhi, ylo, yhi, px, py;
      p = '0;
      if (r.read_failed || r.status_byte == 8'd0 || r.status_byte[3:0] > 4'd2) return p;
      rx = {r.x_high_byte[3:0], r.x_low_byte};
      ry = {r.y_high_byte[3:0], r.y_low_byte};
      tx = {4'd0, rx};
      ty = {4'd0, ry};
      // rotate; subtractions wrap at 16 bits
      case (c.rotation)
         tprs_pkg::ROT_LEFT: begin
            tx = {4'd0, c.raw_y_max} - {4'd0, ry};
            ty = {4'd0, rx};
         end
         tprs_pkg::ROT_INVERTED: begin
            tx = {4'd0, c.raw_x_max} - {4'd0, rx};
            ty = {4'd0, c.raw_y_max} - {4'd0, ry};
         end
         tprs_pkg::ROT_RIGHT: begin
            tx = {4'd0, ry};
            ty = {4'd0, c.raw_x_max} - {4'd0, rx};
         end
         default: ;
      endcase
      // left and right swap the calibration bounds
      if (c.rotation == tprs_pkg::ROT_LEFT || c.rotation == tprs_pkg::ROT_RIGHT) begin
         xlo = int'(c.raw_y_min);
         xhi = int'(c.raw_y_max);
         ylo = int'(c.raw_x_min);
         yhi = int'(c.raw_x_max);
      end else begin
         xlo = int'(c.raw_x_min);
         xhi = int'(c.raw_x_max);
         ylo = int'(c.raw_y_min);
         yhi = int'(c.raw_y_max);
      end
      px = fit_axis(int'(tx), xlo, xhi, int'(c.screen_width) - 1);
      py = fit_axis(int'(ty), ylo, yhi, int'(c.screen_height) - 1);
      if (c.invert_mode[0] && c.screen_width != 12'd0) px = int'(c.screen_width) - 1 - px;
      if (c.invert_mode[1] && c.screen_height != 12'd0) py = int'(c.screen_height) - 1 - py;
      p.touched = 1'b1;
      p.x = px[11:0];
      p.y = py[11:0];
      return p;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // screen sizes lean toward zero, one and full scale
   function automatic logic [11:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'd1;
         2: return 12'd4095;
         default: return 12'($urandom_range(2, 2000));
      endcase
   endfunction

   function automatic void pick_range(output logic [11:0] lo, output logic [11:0] hi);
      int a;
      case ($urandom_range(0, 9))
         0: begin
            // empty or reversed range
            lo = 12'($urandom);
            hi = 12'($urandom_range(0, lo));
         end
         1: begin
            lo = 12'd0;
            hi = 12'd4095;
         end
         default: begin
            a = $urandom_range(0, 2000);
            lo = 12'(a);
            hi = 12'(a + $urandom_range(1, 2095));
         end
      endcase
   endfunction

   function automatic tprs_pkg::cfg_type random_settings();
      tprs_pkg::cfg_type c;
      c.rotation = 2'($urandom_range(0, 3));
      c.invert_mode = 2'($urandom_range(0, 3));
      c.screen_width = pick_size();
      c.screen_height = pick_size();
      pick_range(c.raw_x_min, c.raw_x_max);
      pick_range(c.raw_y_min, c.raw_y_max);
      return c;
   endfunction

   // raw reading mostly around the calibration bounds, sometimes anywhere
   function automatic logic [11:0] near_raw(logic [11:0] a, logic [11:0] b);
      int lo, hi;
      lo = (a < b) ? int'(a) : int'(b);
      hi = (a < b) ? int'(b) : int'(a);
      if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, 4095));
      lo = (lo > 20) ? lo - 20 : 0;
      hi = (hi < 4075) ? hi + 20 : 4095;
      return 12'($urandom_range(lo, hi));
   endfunction

   function automatic report_type make_report(tprs_pkg::cfg_type c);
      report_type  r;
      logic [11:0] rx, ry;
      int          pick;
      pick = $urandom_range(0, 19);
      r.read_failed = (pick == 0);
      case (pick)
         1: r.status_byte = 8'd0;
         2, 3: r.status_byte = {4'($urandom), 4'($urandom_range(3, 15))};
         default: r.status_byte = {4'($urandom), 4'($urandom_range(0, 2))};
      endcase
      rx = near_raw(c.raw_x_min, c.raw_x_max);
      ry = near_raw(c.raw_y_min, c.raw_y_max);
      r.x_high_byte = {4'($urandom), rx[11:8]};
      r.x_low_byte = rx[7:0];
      r.y_high_byte = {4'($urandom), ry[11:8]};
      r.y_low_byte = ry[7:0];
      return r;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [11:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // drain the pipeline, then write every register
   task automatic load_settings(tprs_pkg::cfg_type c);
      @(negedge clock);
      start <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      csr_write(tprs_pkg::REG_ROTATION, {10'($urandom), c.rotation});
      csr_write(tprs_pkg::REG_SCREEN_WIDTH, c.screen_width);
      csr_write(tprs_pkg::REG_SCREEN_HEIGHT, c.screen_height);
      csr_write(tprs_pkg::REG_RAW_X_MIN, c.raw_x_min);
      csr_write(tprs_pkg::REG_RAW_X_MAX, c.raw_x_max);
      csr_write(tprs_pkg::REG_RAW_Y_MIN, c.raw_y_min);
      csr_write(tprs_pkg::REG_RAW_Y_MAX, c.raw_y_max);
      csr_write(tprs_pkg::REG_INVERT_MODE, {10'($urandom), c.invert_mode});
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
      phase_count++;
   endtask

   // hold the report on the request ports until the transfer
   task automatic issue_report(report_type r, int gap, logic typed, point_type want);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_read_failed <= r.read_failed;
      req_status_byte <= r.status_byte;
      req_x_high_byte <= r.x_high_byte;
      req_x_low_byte <= r.x_low_byte;
      req_y_high_byte <= r.y_high_byte;
      req_y_low_byte <= r.y_low_byte;
      typed_valid = typed;
      typed_point = want;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // check each result against the oldest pending point
         if (rsp_strobe) begin
            got = {rsp_touched, rsp_point_x, rsp_point_y};
            if (pending_points.size() == 0) begin
               note_failure($sformatf("unexpected result touched=%0d x=%0d y=%0d",
                                      got.touched, got.x, got.y));
            end else begin
               exp_pt = pending_points.pop_front();
               checked_count++;
               if (got.touched) touched_count++;
               if (got.touched !== exp_pt.touched || got.x !== exp_pt.x ||
                   got.y !== exp_pt.y)
                  note_failure($sformatf("touched %0d/%0d x %0d/%0d y %0d/%0d (exp/got)",
                                         exp_pt.touched, got.touched, exp_pt.x, got.x,
                                         exp_pt.y, got.y));
            end
         end
         // predict the point for a request transfer
         if (start && !busy)
            pending_points.push_back(typed_valid ? typed_point :
               map_touch(cfg_now, {req_read_failed, req_status_byte, req_x_high_byte,
                                   req_x_low_byte, req_y_high_byte, req_y_low_byte}));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_points.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : run
      logic steady;
      int   gap;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED_CFGS[DIRECTED[i].cfg_sel] != cfg_now)
            load_settings(DIRECTED_CFGS[DIRECTED[i].cfg_sel]);
         issue_report(DIRECTED[i].rpt, 0, DIRECTED[i].typed, DIRECTED[i].want);
      end

      // random phases, each under fresh settings
      for (int ph = 0; ph < N_PHASES; ph++) begin
         load_settings(random_settings());
         steady = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gap = (steady || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
            issue_report(make_report(cfg_now), gap, 1'b0, '0);
         end
      end

      // drain, then watch for stray results
      @(negedge clock);
      start <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (tprs_pkg::PIPE_LAT + 4) @(posedge clock);
      if (pending_points.size() != 0)
         note_failure($sformatf("%0d results never arrived", pending_points.size()));

      $display("Sent %0d touch reports under %0d register settings, all rotations and mirrors.",
               sent_count, phase_count);
      $display("Checked %0d results (%0d touches), %0d failures.", checked_count,
               touched_count, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/tprs_pkg.sv
hw/rtl/tprs_front.sv
hw/rtl/tprs_div_cell.sv
hw/rtl/touch_point_rotate_and_scale.sv
verif/tb_top.sv
